[rtl/assert_macros.svh]
// Assertion macros for the layer derivative moment reduce block.
// Needs clk and rst_n in the scope of use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LDMR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Expression must never be true outside reset.
`define LDMR_NEVER(label, expr, msg) \
    `LDMR_ASSERT(label, !(expr), msg)

`endif

[rtl/ldmr_pkg.sv]
// Shared types and defaults for the layer derivative moment reduce block.
// No dependencies; used by the controller, the datapath and the top level.
package ldmr_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ACC_WIDTH_DEF  = 48;

    typedef enum logic [2:0] {
        STEP_PROD,
        STEP_COV,
        STEP_SQ,
        STEP_CROSS,
        STEP_ELEM,
        STEP_FINAL,
        STEP_OUT
    } step_t;

    typedef struct packed {
        logic  load;
        logic  run;
        step_t step;
        logic  finish;
    } ldmr_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } ldmr_status_t;

endpackage

[rtl/ldmr_mul.sv]
// Signed fixed-point multiplier: exact product, round half away from zero,
// saturate to the data range. Depends on ldmr_pkg for parameter defaults.
module ldmr_mul #(
    parameter int DATA_WIDTH = ldmr_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = ldmr_pkg::FRAC_BITS_DEF
) (
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [DATA_WIDTH-1:0] b,
    output logic signed [DATA_WIDTH-1:0] y,
    output logic                         clip
);
    localparam int PW = 2 * DATA_WIDTH;
    localparam int RW = PW + 1;
    localparam int MW = RW - FRAC_BITS;
    localparam logic [MW-1:0] MAX_POS =
        {{(MW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [RW-1:0] HALF = RW'(1) << (FRAC_BITS - 1);

    logic                  neg;
    logic [DATA_WIDTH-1:0] ua;
    logic [DATA_WIDTH-1:0] ub;
    logic [PW-1:0]         prod;
    logic [RW-1:0]         rnd;
    logic [MW-1:0]         mag_full;
    logic [MW-1:0]         limit;
    logic [MW-1:0]         mag;
    logic [DATA_WIDTH-1:0] mag_dw;

    always_comb
    begin
        neg      = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
        ua       = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
        ub       = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
        prod     = ua * ub;
        rnd      = RW'(prod) + HALF;
        mag_full = rnd[RW-1:FRAC_BITS];
        limit    = MAX_POS + MW'(neg);
        clip     = mag_full > limit;
        mag      = clip ? limit : mag_full;
        mag_dw   = mag[DATA_WIDTH-1:0];
        y        = neg ? signed'(~mag_dw + 1'b1) : signed'(mag_dw);
    end

endmodule

[rtl/ldmr_dp.sv]
// Datapath: input capture, two shared multipliers, saturating accumulators
// and the output register. Depends on ldmr_pkg and ldmr_mul.
module ldmr_dp #(
    parameter int DATA_WIDTH = ldmr_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = ldmr_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH  = ldmr_pkg::ACC_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [DATA_WIDTH-1:0] partial_mean_out,
    input  logic signed [DATA_WIDTH-1:0] next_deriv_mean,
    input  logic signed [DATA_WIDTH-1:0] next_weight_mean,
    input  logic signed [DATA_WIDTH-1:0] deriv_weight_cov,
    input  logic signed [DATA_WIDTH-1:0] node_mean,
    input  logic signed [DATA_WIDTH-1:0] node_var,
    input  logic signed [DATA_WIDTH-1:0] out_layer_mean,
    input  logic signed [DATA_WIDTH-1:0] out_layer_var,
    input  logic                         last_term,
    input  ldmr_pkg::ldmr_cmd_t          cmd,
    output ldmr_pkg::ldmr_status_t       sts,
    input  logic                         out_stall,
    output logic                         out_valid,
    output logic signed [DATA_WIDTH-1:0] layer_mean,
    output logic signed [DATA_WIDTH-1:0] layer_var,
    output logic                         saturated
);
    import ldmr_pkg::*;

    localparam int SW = ((ACC_WIDTH > DATA_WIDTH) ? ACC_WIDTH : DATA_WIDTH) + 1;
    localparam logic [SW-1:0] ACC_MAX_S =
        {{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic [SW-1:0] ACC_MIN_S = ~ACC_MAX_S;
    localparam logic [SW-1:0] DAT_MAX_S =
        {{(SW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [SW-1:0] DAT_MIN_S = ~DAT_MAX_S;

    function automatic logic [SW:0] fit_acc(input logic signed [SW-1:0] s);
        logic [SW-ACC_WIDTH:0] top;
        logic [SW-1:0]         v;
        logic                  c;
        top = s[SW-1:ACC_WIDTH-1];
        c   = !((&top) || !(|top));
        v   = s;
        if (c)
        begin
            v = s[SW-1] ? ACC_MIN_S : ACC_MAX_S;
        end
        return {c, v};
    endfunction

    function automatic logic [SW:0] fit_data(input logic signed [SW-1:0] s);
        logic [SW-DATA_WIDTH:0] top;
        logic [SW-1:0]          v;
        logic                   c;
        top = s[SW-1:DATA_WIDTH-1];
        c   = !((&top) || !(|top));
        v   = s;
        if (c)
        begin
            v = s[SW-1] ? DAT_MIN_S : DAT_MAX_S;
        end
        return {c, v};
    endfunction

    logic signed [DATA_WIDTH-1:0] p_reg, dn_reg, wm_reg, cv_reg;
    logic signed [DATA_WIDTH-1:0] nm_reg, nv_reg, om_reg, ov_reg;
    logic                         last_reg;
    logic signed [DATA_WIDTH-1:0] ra_reg, ra_next;
    logic signed [DATA_WIDTH-1:0] rb_reg, rb_next;
    logic signed [ACC_WIDTH-1:0]  mean_reg, mean_next;
    logic signed [ACC_WIDTH-1:0]  cov_reg, cov_next;
    logic                         clip_reg, clip_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0] layer_mean_reg, layer_mean_next;
    logic signed [DATA_WIDTH-1:0] layer_var_reg, layer_var_next;
    logic                         saturated_reg, saturated_next;

    logic signed [DATA_WIDTH-1:0] ax, ay, bx, by, ya, yb;
    logic                         clip_a, clip_b, en_a, en_b, wr_a, wr_b;
    logic signed [SW-1:0]         cov_opnd;
    logic [SW:0]                  f_mean, f_cov, f_dbl;
    logic [SW:0]                  f_m1, f_m2, f_v1, f_v2;

    ldmr_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_a (
        .a    (ax),
        .b    (ay),
        .y    (ya),
        .clip (clip_a)
    );

    ldmr_mul #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_mul_b (
        .a    (bx),
        .b    (by),
        .y    (yb),
        .clip (clip_b)
    );

    // Operand selection and which lanes count toward the clip flag.
    always_comb
    begin
        ax   = nm_reg;
        ay   = nm_reg;
        bx   = nm_reg;
        by   = om_reg;
        en_a = 1'b0;
        en_b = 1'b0;
        wr_a = 1'b0;
        wr_b = 1'b0;
        unique case (cmd.step)
            STEP_PROD:
            begin
                ax = dn_reg;  ay = wm_reg;  bx = p_reg;   by = p_reg;
                en_a = 1'b1;  en_b = 1'b1;  wr_a = 1'b1;  wr_b = 1'b1;
            end
            STEP_COV:
            begin
                ax = ra_reg;  ay = cv_reg;  bx = nv_reg;  by = rb_reg;
                en_a = 1'b1;  en_b = 1'b1;  wr_a = 1'b1;  wr_b = 1'b1;
            end
            STEP_SQ:
            begin
                ax = ra_reg;  ay = ra_reg;  bx = ra_reg;  by = p_reg;
                en_a = 1'b1;  en_b = 1'b1;  wr_a = 1'b1;  wr_b = 1'b1;
            end
            STEP_CROSS:
            begin
                ax = nm_reg;  ay = nm_reg;  bx = rb_reg;  by = nm_reg;
                en_a = last_reg;  en_b = 1'b1;  wr_a = 1'b1;  wr_b = 1'b1;
            end
            STEP_ELEM:
            begin
                ax = ov_reg;  ay = ra_reg;  bx = nv_reg;  by = ov_reg;
                en_a = last_reg;  en_b = last_reg;  wr_a = 1'b1;  wr_b = 1'b1;
            end
            STEP_FINAL:
            begin
                bx = nm_reg;  by = om_reg;
                en_b = 1'b1;  wr_b = 1'b1;
            end
            default:
            begin
                en_a = 1'b0;
            end
        endcase
        en_a = en_a & cmd.run;
        en_b = en_b & cmd.run;
        wr_a = wr_a & cmd.run;
        wr_b = wr_b & cmd.run;
    end

    always_comb
    begin
        f_dbl = fit_data(SW'(rb_reg) + SW'(rb_reg));
        case (cmd.step)
            STEP_SQ:    cov_opnd = SW'(rb_reg);
            STEP_CROSS: cov_opnd = SW'(ra_reg);
            STEP_ELEM:  cov_opnd = signed'(f_dbl[SW-1:0]);
            default:    cov_opnd = SW'(rb_reg);
        endcase
        f_mean = fit_acc(SW'(mean_reg) + SW'(ra_reg));
        f_cov  = fit_acc(SW'(cov_reg) + cov_opnd);
        f_m1   = fit_acc(SW'(mean_reg) + SW'(rb_reg));
        f_m2   = fit_data(signed'(f_m1[SW-1:0]));
        f_v1   = fit_acc(SW'(cov_reg) + SW'(ra_reg));
        f_v2   = fit_data(signed'(f_v1[SW-1:0]));

        ra_next   = wr_a ? ya : ra_reg;
        rb_next   = wr_b ? yb : rb_reg;
        mean_next = mean_reg;
        cov_next  = cov_reg;
        clip_next = clip_reg | (en_a & clip_a) | (en_b & clip_b);

        if (cmd.run)
        begin
            case (cmd.step)
                STEP_SQ:
                begin
                    mean_next = f_mean[ACC_WIDTH-1:0];
                    cov_next  = f_cov[ACC_WIDTH-1:0];
                    clip_next = clip_next | f_mean[SW] | f_cov[SW];
                end
                STEP_CROSS, STEP_FINAL:
                begin
                    cov_next  = f_cov[ACC_WIDTH-1:0];
                    clip_next = clip_next | f_cov[SW];
                end
                STEP_ELEM:
                begin
                    cov_next  = f_cov[ACC_WIDTH-1:0];
                    clip_next = clip_next | f_cov[SW] | f_dbl[SW];
                end
                default:
                begin
                    cov_next = cov_reg;
                end
            endcase
        end

        layer_mean_next = layer_mean_reg;
        layer_var_next  = layer_var_reg;
        saturated_next  = saturated_reg;
        out_valid_next  = out_valid_reg & out_stall;
        if (cmd.finish)
        begin
            layer_mean_next = f_m2[DATA_WIDTH-1:0];
            layer_var_next  = f_v2[DATA_WIDTH-1:0];
            saturated_next  = clip_reg | f_m1[SW] | f_m2[SW] | f_v1[SW] | f_v2[SW];
            out_valid_next  = 1'b1;
            mean_next       = '0;
            cov_next        = '0;
            clip_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg      <= '0;
            cov_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mean_reg      <= mean_next;
            cov_reg       <= cov_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_reg    <= partial_mean_out;
            dn_reg   <= next_deriv_mean;
            wm_reg   <= next_weight_mean;
            cv_reg   <= deriv_weight_cov;
            nm_reg   <= node_mean;
            nv_reg   <= node_var;
            om_reg   <= out_layer_mean;
            ov_reg   <= out_layer_var;
            last_reg <= last_term;
        end
        ra_reg         <= ra_next;
        rb_reg         <= rb_next;
        layer_mean_reg <= layer_mean_next;
        layer_var_reg  <= layer_var_next;
        saturated_reg  <= saturated_next;
    end

    assign sts.last     = last_reg;
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign layer_mean   = layer_mean_reg;
    assign layer_var    = layer_var_reg;
    assign saturated    = saturated_reg;

endmodule

[rtl/ldmr_ctrl.sv]
// Controller: sequences the multiply and accumulate steps of one term and
// gates input transfers. Depends on ldmr_pkg.
module ldmr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output ldmr_pkg::ldmr_cmd_t    cmd,
    input  ldmr_pkg::ldmr_status_t sts
);
    import ldmr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   take;
    logic   load;

    always_comb
    begin
        take = (state_reg == ST_IDLE) ||
               ((step_reg == STEP_ELEM) && !sts.last) ||
               ((step_reg == STEP_OUT) && sts.out_free);
        load = in_valid && take;

        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next = ST_BUSY;
                    step_next  = STEP_PROD;
                end
            end
            ST_BUSY:
            begin
                unique case (step_reg)
                    STEP_PROD:  step_next = STEP_COV;
                    STEP_COV:   step_next = STEP_SQ;
                    STEP_SQ:    step_next = STEP_CROSS;
                    STEP_CROSS: step_next = STEP_ELEM;
                    STEP_ELEM:
                    begin
                        if (sts.last)
                        begin
                            step_next = STEP_FINAL;
                        end
                        else if (load)
                        begin
                            step_next = STEP_PROD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    STEP_FINAL: step_next = STEP_OUT;
                    STEP_OUT:
                    begin
                        if (load)
                        begin
                            step_next = STEP_PROD;
                        end
                        else if (sts.out_free)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_PROD;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign in_stall   = !take;
    assign cmd.load   = load;
    assign cmd.run    = (state_reg == ST_BUSY);
    assign cmd.step   = step_reg;
    assign cmd.finish = (state_reg == ST_BUSY) && (step_reg == STEP_OUT) && sts.out_free;

endmodule

[rtl/layer_derivative_moment_reduce_core.sv]
// Top level of the layer derivative moment reduce block.
// Depends on ldmr_pkg, ldmr_ctrl, ldmr_dp, ldmr_mul and assert_macros.svh.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  eight Q terms, last_term
//   output   out        out_valid / out_stall layer_mean, layer_var, saturated
//
// A term steps PROD, COV, SQ, CROSS, ELEM, a dependent chain through the two
// multipliers; a last term adds FINAL, OUT and any wait on the output register.
// The next term transfers in the last cycle of the current one.
// Reset clears the accumulators, the clip flag and the output valid.
// While a result waits under out_stall, terms that are not last keep flowing.
`include "assert_macros.svh"

module layer_derivative_moment_reduce_core #(
    parameter int DATA_WIDTH = ldmr_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = ldmr_pkg::FRAC_BITS_DEF,
    parameter int ACC_WIDTH  = ldmr_pkg::ACC_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] partial_mean_out,
    input  logic signed [DATA_WIDTH-1:0] next_deriv_mean,
    input  logic signed [DATA_WIDTH-1:0] next_weight_mean,
    input  logic signed [DATA_WIDTH-1:0] deriv_weight_cov,
    input  logic signed [DATA_WIDTH-1:0] node_mean,
    input  logic signed [DATA_WIDTH-1:0] node_var,
    input  logic signed [DATA_WIDTH-1:0] out_layer_mean,
    input  logic signed [DATA_WIDTH-1:0] out_layer_var,
    input  logic                         last_term,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] layer_mean,
    output logic signed [DATA_WIDTH-1:0] layer_var,
    output logic                         saturated
);
    import ldmr_pkg::*;

    ldmr_cmd_t    cmd;
    ldmr_status_t sts;
    logic         in_xfer;
    logic         term_start;

    ldmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    ldmr_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .partial_mean_out (partial_mean_out),
        .next_deriv_mean  (next_deriv_mean),
        .next_weight_mean (next_weight_mean),
        .deriv_weight_cov (deriv_weight_cov),
        .node_mean        (node_mean),
        .node_var         (node_var),
        .out_layer_mean   (out_layer_mean),
        .out_layer_var    (out_layer_var),
        .last_term        (last_term),
        .cmd              (cmd),
        .sts              (sts),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .layer_mean       (layer_mean),
        .layer_var        (layer_var),
        .saturated        (saturated)
    );

    assign in_xfer    = in_valid && !in_stall;
    assign term_start = cmd.run && (cmd.step == STEP_PROD);

    `LDMR_ASSERT(a_start_term, in_xfer |=> term_start, "transfer did not start a term")
    `LDMR_ASSERT(a_out_from_finish, $rose(out_valid) |-> $past(cmd.finish), "no finish")
    `LDMR_NEVER(a_finish_last, cmd.finish && !sts.last, "finish on a term that is not last")

endmodule
